/* hw/rtl/depth_minmax_gray_normalizer_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the depth min/max gray normalizer checker
// Labeled next-cycle implications on the top level's clock and reset.
// ----------------------------------------------------------------------------
`ifndef DEPTH_MINMAX_GRAY_NORMALIZER_TOP_MACROS_SVH
`define DEPTH_MINMAX_GRAY_NORMALIZER_TOP_MACROS_SVH

// Next-cycle implication, ignored while reset is held.
`define DMGN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dmgn check failed");

// Next-cycle implication that also holds across reset.
`define DMGN_ASSERT_NEXT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("dmgn reset check failed");

`endif

/* hw/rtl/dmgn_pkg.sv */
// ----------------------------------------------------------------------------
// dmgn_pkg
// Shared types and constants of the depth min/max gray normalizer.
// ----------------------------------------------------------------------------
package dmgn_pkg;

    localparam int DEPTH_IN_W = 16;   // width of the depth field on the port
    localparam int GRAY_W     = 8;    // gray result and quotient width
    localparam int CNT_W      = $clog2(GRAY_W);

    localparam logic [GRAY_W-1:0] GRAY_FULL = '1;   // 255
    localparam logic [GRAY_W-1:0] GRAY_NONE = '0;

    localparam logic CMD_MEASURE = 1'b0;
    localparam logic CMD_RENDER  = 1'b1;

    // Divider status seen by the controller
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

/* hw/rtl/dmgn_div.sv */
// ----------------------------------------------------------------------------
// dmgn_div
// Restoring divider, one quotient bit per cycle, for an 8-bit quotient.
// ----------------------------------------------------------------------------
module dmgn_div import dmgn_pkg::*; #(
    parameter int DW = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DW+GRAY_W-1:0]  i_num,    // must satisfy i_num < den * 2**GRAY_W
    input  logic [DW-1:0]         i_den,    // nonzero
    output t_div_stat             o_stat,
    output logic [GRAY_W-1:0]     o_quo
);

    logic              r_busy, n_busy;
    logic [CNT_W-1:0]  r_cnt,  n_cnt;
    logic [DW-1:0]     r_rem,  n_rem;
    logic [DW-1:0]     r_den,  n_den;
    logic [GRAY_W-1:0] r_low,  n_low;
    logic [GRAY_W-1:0] r_quo,  n_quo;
    logic [DW:0]       w_trial;
    logic [DW:0]       w_diff;
    logic              w_fit;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GRAY_W - 1);

    assign w_trial = {r_rem, r_low[GRAY_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_fit   = (w_trial >= {1'b0, r_den});

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_low  = r_low;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = i_num[DW+GRAY_W-1:GRAY_W];
            n_low  = i_num[GRAY_W-1:0];
            n_den  = i_den;
        end else if (r_busy) begin
            // shift in the next numerator bit, subtract when it fits
            n_rem = w_fit ? w_diff[DW-1:0] : w_trial[DW-1:0];
            n_quo = {r_quo[GRAY_W-2:0], w_fit};
            n_low = {r_low[GRAY_W-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_LAST) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_den <= n_den;
        r_low <= n_low;
        r_quo <= n_quo;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_busy && (r_cnt == CNT_LAST);
    assign o_quo       = r_quo;

endmodule

/* hw/rtl/depth_minmax_gray_normalizer_top.sv */
// ----------------------------------------------------------------------------
// depth_minmax_gray_normalizer_top
// Inverted grayscale view of a depth frame, scaled to the frame's own range.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  in      | to block  | i_valid / o_ready  | i_cmd, i_depth, i_last
//  out     | from block| o_valid / i_ready  | o_gray, o_frame_end
//
//  A measure item updates min/max at the accepting edge. A render item steps
//  through PREP, which clamps the difference and forms the range, LOAD, which
//  loads diff*255 into the divider, DIV, one quotient bit a cycle, and DONE,
//  which loads the result, before the block is back in idle and takes the next
//  item. A stalled output holds a finished render item back in DONE; no other
//  items are taken while it waits. Reset (synchronous, active low) clears min
//  to all ones and max to zero.
//
module depth_minmax_gray_normalizer_top import dmgn_pkg::*; #(
    parameter int DEPTH_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_cmd,
    input  logic [DEPTH_IN_W-1:0] i_depth,
    input  logic                  i_last,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [GRAY_W-1:0]     o_gray,
    output logic                  o_frame_end
);

    localparam int DW = DEPTH_BITS;
    localparam logic [DW-1:0] MIN_RST = '1;
    localparam logic [DW-1:0] MAX_RST = '0;
    localparam logic [DW-1:0] ONE     = DW'(1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PREP = 5'b00010,
        S_LOAD = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [DW-1:0]     r_min,   n_min;
    logic [DW-1:0]     r_max,   n_max;
    logic [DW-1:0]     r_d,     n_d;
    logic              r_last,  n_last;
    logic [DW-1:0]     r_range, n_range;
    logic [DW-1:0]     r_diff,  n_diff;
    logic              r_ovalid, n_ovalid;
    logic [GRAY_W-1:0] r_gray,  n_gray;
    logic              r_fend,  n_fend;

    logic [DW-1:0]        w_d;
    logic                 w_accept;
    logic [DW-1:0]        w_range;
    logic [DW-1:0]        w_sub;
    logic [DW+GRAY_W-1:0] w_num;
    logic                 w_slot;
    t_div_stat            w_dstat;
    logic [GRAY_W-1:0]    w_quo;

    // Depth bits above DEPTH_BITS are ignored.
    assign w_d      = i_depth[DW-1:0];
    assign w_accept = i_valid && o_ready;
    assign w_slot   = !r_ovalid || i_ready;

    // range = max - min, or 1 when that is not positive
    assign w_range = (r_max > r_min) ? (r_max - r_min) : ONE;
    assign w_sub   = r_d - r_min;

    // numerator = diff * 255 = diff * 256 - diff
    assign w_num = {r_diff, {GRAY_W{1'b0}}} - {{GRAY_W{1'b0}}, r_diff};

    always_comb begin
        n_state  = r_state;
        n_min    = r_min;
        n_max    = r_max;
        n_d      = r_d;
        n_last   = r_last;
        n_range  = r_range;
        n_diff   = r_diff;
        n_ovalid = r_ovalid && !i_ready;
        n_gray   = r_gray;
        n_fend   = r_fend;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_cmd == CMD_MEASURE) begin
                        // widen the running range with nonzero depths only
                        if (w_d != '0) begin
                            if (w_d < r_min) n_min = w_d;
                            if (w_d > r_max) n_max = w_d;
                        end
                    end else begin
                        n_d     = w_d;
                        n_last  = i_last;
                        n_state = S_PREP;
                    end
                end
            end
            S_PREP: begin
                n_range = w_range;
                // clamp d - min to 0..range
                priority if (r_d <= r_min) begin
                    n_diff = '0;
                end else if (w_sub > w_range) begin
                    n_diff = w_range;
                end else begin
                    n_diff = w_sub;
                end
                // the last render item of a frame restores min/max
                if (r_last) begin
                    n_min = MIN_RST;
                    n_max = MAX_RST;
                end
                n_state = S_LOAD;
            end
            S_LOAD: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_dstat.done) n_state = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free
                if (w_slot) begin
                    n_ovalid = 1'b1;
                    n_gray   = (r_d == '0) ? GRAY_NONE : (GRAY_FULL - w_quo);
                    n_fend   = r_last;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_min    <= MIN_RST;
            r_max    <= MAX_RST;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_min    <= n_min;
            r_max    <= n_max;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d     <= n_d;
        r_last  <= n_last;
        r_range <= n_range;
        r_diff  <= n_diff;
        r_gray  <= n_gray;
        r_fend  <= n_fend;
    end

    dmgn_div #(
        .DW (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_LOAD),
        .i_num   (w_num),
        .i_den   (r_range),
        .o_stat  (w_dstat),
        .o_quo   (w_quo)
    );

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = r_ovalid;
    assign o_gray      = r_gray;
    assign o_frame_end = r_fend;

endmodule

/* hw/rtl/dmgn_chk.sv */
// ----------------------------------------------------------------------------
// dmgn_chk
// Port-level checks of the depth min/max gray normalizer, bound to the top.
// ----------------------------------------------------------------------------
`include "depth_minmax_gray_normalizer_top_macros.svh"

module dmgn_chk import dmgn_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input logic              i_cmd,
    input logic              o_valid,
    input logic              i_ready,
    input logic [GRAY_W-1:0] o_gray,
    input logic              o_frame_end
);

    // hold a stalled result
    `DMGN_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_gray) && $stable(o_frame_end))

    // a render item occupies the block
    `DMGN_ASSERT_NEXT(a_render_busy, i_valid && o_ready && i_cmd == CMD_RENDER, !o_ready)

    // a measure item never blocks the next one
    `DMGN_ASSERT_NEXT(a_measure_free, i_valid && o_ready && i_cmd == CMD_MEASURE, o_ready)

    // reset drops any result and opens the input
    `DMGN_ASSERT_NEXT_RST(a_reset_clear, !i_rst_n, !o_valid && o_ready)

endmodule

bind depth_minmax_gray_normalizer_top dmgn_chk u_dmgn_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .i_cmd       (i_cmd),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_gray      (o_gray),
    .o_frame_end (o_frame_end)
);
